// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers, reset-qualified on arst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, checked at every rising clk edge outside reset
`define TMS_ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// same-cycle implication
`define TMS_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== design/tms_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tms_pkg
// Types and constants shared by the tip measure sequencer modules.
// ----------------------------------------------------------------------------
package tms_pkg;

	localparam int SAMPLE_W  = 12;
	localparam int TEMP_W    = 16;
	localparam int COUNT_W   = 16;
	localparam int DEV_W     = 12;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;

	// configuration reset values
	localparam logic [COUNT_W-1:0]  CHECK_INTERVAL_RST = 16'd500;
	localparam logic [DEV_W-1:0]    MAX_DEVIATION_RST  = 12'd50;
	localparam logic [SAMPLE_W-1:0] TIP_THRESHOLD_RST  = 12'd4000;
	localparam logic [TEMP_W-1:0]   ERROR_TEMP_RST     = 16'hFFFF;

	// temperature = avg * 100 / 750 + 25, i.e. floor(2 * avg / 15) + 25
	localparam int TEMP_OFFSET = 25;
	localparam int TEMP_DEN    = 15;
	localparam int TEMP_X_W    = SAMPLE_W + 1;
	localparam int TEMP_SHIFT  = TEMP_X_W + $clog2(TEMP_DEN);
	localparam int TEMP_RECIP  = ((1 << TEMP_SHIFT) + TEMP_DEN - 1) / TEMP_DEN;
	localparam int TEMP_RCP_W  = TEMP_X_W + 1;
	localparam int TEMP_Q_W    = 10;

	typedef enum logic [1:0] {
		CMD_HALF_CYCLE = 2'd0,
		CMD_DELAY_TICK = 2'd1,
		CMD_SAMPLE     = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		TIP_ABSENT    = 2'd0,
		TIP_PRESENT   = 2'd1,
		TIP_DEV_FAULT = 2'd2
	} tip_status_t;

	typedef enum logic [1:0] {
		TSEL_KEEP  = 2'd0,
		TSEL_NEW   = 2'd1,
		TSEL_ERROR = 2'd2
	} temp_sel_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CHECK_INTERVAL = 2'd0,
		REG_MAX_DEVIATION  = 2'd1,
		REG_TIP_THRESHOLD  = 2'd2,
		REG_ERROR_TEMP     = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [1:0]          command;
		logic [SAMPLE_W-1:0] sample;
		logic                system_active;
	} tms_in_t;

	typedef struct packed {
		logic [TEMP_W-1:0] tip_temperature;
		logic [1:0]        tip_status;
		logic              heater_allowed;
		logic              clamp_engaged;
		logic              check_drive;
		logic              start_conversion;
		logic              conversion_done;
		logic              run_heater_control;
	} tms_out_t;

	typedef struct packed {
		logic [COUNT_W-1:0]  check_interval_cycles;
		logic [DEV_W-1:0]    max_deviation;
		logic [SAMPLE_W-1:0] tip_present_threshold;
		logic [TEMP_W-1:0]   error_temperature;
	} tms_cfg_t;

	// handoff from the sequencing stage to the temperature stage
	typedef struct packed {
		tip_status_t         tip_status;
		logic                heater_allowed;
		logic                clamp_engaged;
		logic                check_drive;
		logic                start_conversion;
		logic                conversion_done;
		logic                run_heater_control;
		temp_sel_t           temp_sel;
		logic [SAMPLE_W-1:0] avg;
	} tms_s1_t;

endpackage

// ===== design/tms_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tms_stream_if
// Valid/ready stream carrying one payload struct per transaction.
// ----------------------------------------------------------------------------
interface tms_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== design/thermocouple_tip_measure_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thermocouple_tip_measure_sequencer
// Sequences tip thermocouple measurement: check counter, delay phases,
// N-sample conversions, tip presence and temperature with deviation check.
// ----------------------------------------------------------------------------
// Usage:
//   events  (sink)  : one transaction per event: AC half cycle, delay timer
//                     tick or ADC sample, plus the system_active flag.
//   results (source): exactly one transaction per event, carrying the
//                     temperature, tip status, pin status and the pulses
//                     caused by that event.
//   cfg_we/cfg_index/cfg_wdata: register writes, only while no transaction
//                     is in flight.
// Path: an accepted event is registered in the sequencing register, then in
//   the temperature/result register, which presents it as a valid result.
// Throughput: one event per cycle while results.ready stays high; the state
//   update, the running sum, min/max and the average multiply are all combinational.
// Reset: pins go to heater allowed, clamp engaged, check off; counters and
//   accumulators clear, temperature reads 0, registers take defaults.
// Stall: with results.ready low the result holds; one more event is taken
//   into the sequencing register, then events.ready drops.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module thermocouple_tip_measure_sequencer
	import tms_pkg::*;
#(
	parameter int SAMPLES_PER_CONVERSION = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	tms_stream_if.sink           events,
	tms_stream_if.source         results
);

	tms_cfg_t cfg;
	logic     s1_valid;
	logic     s1_take;
	tms_s1_t  s1;

	tms_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	tms_core #(
		.SAMPLES_PER_CONVERSION (SAMPLES_PER_CONVERSION)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.events   (events),
		.cfg      (cfg),
		.s1_take  (s1_take),
		.s1_valid (s1_valid),
		.s1       (s1)
	);

	tms_temp_stage u_temp (
		.clk               (clk),
		.arst_n            (arst_n),
		.s1_valid          (s1_valid),
		.s1                (s1),
		.error_temperature (cfg.error_temperature),
		.s1_take           (s1_take),
		.results           (results)
	);

	// the check pin is only driven between the first delay phase and completion
	`TMS_ASSERT_IMPLY(a_check_blocks_heater, results.valid && results.data.check_drive, !results.data.heater_allowed && !results.data.clamp_engaged, "check drive with heater or clamp on")
	`TMS_ASSERT_IMPLY(a_run_needs_good_temp, results.valid && results.data.run_heater_control, results.data.conversion_done && results.data.tip_status == TIP_PRESENT, "heater control request without valid temperature")
	`TMS_ASSERT_IMPLY(a_stall_blocks_input, s1_valid && !s1_take, !events.ready, "input taken while pipeline is full")
	`TMS_ASSERT_CLK(a_pulses_exclusive, !(results.valid && results.data.start_conversion && results.data.conversion_done), "start and done in one transaction")

endmodule

// ===== design/tms_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tms_cfg_regs
// Configuration register bank written through a plain indexed write port.
// ----------------------------------------------------------------------------
module tms_cfg_regs
	import tms_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	output tms_cfg_t             cfg
);

	tms_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.check_interval_cycles <= CHECK_INTERVAL_RST;
			cfg_q.max_deviation         <= MAX_DEVIATION_RST;
			cfg_q.tip_present_threshold <= TIP_THRESHOLD_RST;
			cfg_q.error_temperature     <= ERROR_TEMP_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_CHECK_INTERVAL: cfg_q.check_interval_cycles <= cfg_wdata[COUNT_W-1:0];
				REG_MAX_DEVIATION:  cfg_q.max_deviation         <= cfg_wdata[DEV_W-1:0];
				REG_TIP_THRESHOLD:  cfg_q.tip_present_threshold <= cfg_wdata[SAMPLE_W-1:0];
				REG_ERROR_TEMP:     cfg_q.error_temperature     <= cfg_wdata[TEMP_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== design/tms_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tms_core
// Sequencing state: check counter, delay phases, sample accumulators and
// conversion completion. Registers one handoff per accepted transaction.
// ----------------------------------------------------------------------------
module tms_core
	import tms_pkg::*;
#(
	parameter int SAMPLES_PER_CONVERSION = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	tms_stream_if.sink    events,
	input  tms_cfg_t      cfg,
	input  logic          s1_take,
	output logic          s1_valid,
	output tms_s1_t       s1
);

	localparam int N      = SAMPLES_PER_CONVERSION;
	localparam int IDX_W  = (N > 1) ? $clog2(N) : 1;
	localparam int SUM_W  = $clog2(N * ((1 << SAMPLE_W) - 1) + 1);
	// exact floor(sum / N) by reciprocal multiply for sums below 2**SUM_W
	localparam int DIV_S  = SUM_W + $clog2(N);
	localparam int DIV_M  = ((1 << DIV_S) + N - 1) / N;
	localparam int PROD_W = 2 * SUM_W + 1;
	localparam logic [SUM_W:0]   DIV_M_V = (SUM_W + 1)'(DIV_M);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(N - 1);

	logic                first_phase_q, first_phase_d;
	logic [COUNT_W-1:0]  half_count_q, half_count_d;
	logic                checking_q, checking_d;
	tip_status_t         presence_q, presence_d;
	logic [SUM_W-1:0]    sum_q, sum_d;
	logic [SAMPLE_W-1:0] min_q, min_d;
	logic [SAMPLE_W-1:0] max_q, max_d;
	logic [IDX_W-1:0]    idx_q, idx_d;
	logic                heater_q, heater_d;
	logic                clamp_q, clamp_d;
	logic                check_q, check_d;

	logic                s1_valid_q;
	tms_s1_t             s1_q, s1_d;

	tms_in_t             item;
	logic                accept;
	logic [SUM_W-1:0]    new_sum;
	logic [SAMPLE_W-1:0] new_min, new_max;
	logic [PROD_W-1:0]   prod;
	logic [SAMPLE_W-1:0] avg;
	logic [SAMPLE_W:0]   upper;
	logic [SAMPLE_W:0]   min_plus_dev;

	assign item         = events.data;
	assign events.ready = !s1_valid_q || s1_take;
	assign accept       = events.valid && events.ready;

	assign new_sum = sum_q + SUM_W'(item.sample);
	assign new_min = (item.sample < min_q) ? item.sample : min_q;
	assign new_max = (item.sample > max_q) ? item.sample : max_q;
	assign prod    = PROD_W'(new_sum) * PROD_W'(DIV_M_V);
	assign avg     = prod[DIV_S +: SAMPLE_W];

	// deviation window without signed math: max > avg+dev, min < avg-dev
	assign upper        = {1'b0, avg} + {1'b0, cfg.max_deviation};
	assign min_plus_dev = {1'b0, new_min} + {1'b0, cfg.max_deviation};

	always_comb begin
		first_phase_d = first_phase_q;
		half_count_d  = half_count_q;
		checking_d    = checking_q;
		presence_d    = presence_q;
		sum_d         = sum_q;
		min_d         = min_q;
		max_d         = max_q;
		idx_d         = idx_q;
		heater_d      = heater_q;
		clamp_d       = clamp_q;
		check_d       = check_q;
		s1_d          = '0;
		s1_d.temp_sel = TSEL_KEEP;
		s1_d.avg      = avg;

		case (cmd_t'(item.command))
			CMD_HALF_CYCLE: begin
				if (half_count_q != '1) begin
					half_count_d = half_count_q + 1'b1;
				end
			end
			CMD_DELAY_TICK: begin
				if (first_phase_q) begin
					first_phase_d = 1'b0;
					heater_d      = 1'b0;
					clamp_d       = 1'b0;
					if (half_count_q > cfg.check_interval_cycles) begin
						checking_d   = 1'b1;
						check_d      = 1'b1;
						half_count_d = '0;
					end
				end else begin
					first_phase_d         = 1'b1;
					s1_d.start_conversion = 1'b1;
					sum_d                 = '0;
					min_d                 = '1;
					max_d                 = '0;
					idx_d                 = '0;
				end
			end
			CMD_SAMPLE: begin
				sum_d = new_sum;
				min_d = new_min;
				max_d = new_max;
				idx_d = idx_q + 1'b1;
				if (idx_q == IDX_LAST) begin
					s1_d.conversion_done = 1'b1;
					heater_d             = 1'b1;
					clamp_d              = 1'b1;
					if (checking_q) begin
						checking_d = 1'b0;
						check_d    = 1'b0;
						presence_d = (avg < cfg.tip_present_threshold) ? TIP_PRESENT
						                                                : TIP_ABSENT;
					end else if (presence_q == TIP_PRESENT) begin
						if ({1'b0, new_max} > upper || min_plus_dev < {1'b0, avg}) begin
							s1_d.temp_sel = TSEL_ERROR;
							presence_d    = TIP_DEV_FAULT;
						end else begin
							s1_d.temp_sel           = TSEL_NEW;
							s1_d.run_heater_control = item.system_active;
						end
					end
					sum_d = '0;
					min_d = '1;
					max_d = '0;
					idx_d = '0;
				end
			end
			default: ;
		endcase

		s1_d.tip_status     = presence_d;
		s1_d.heater_allowed = heater_d;
		s1_d.clamp_engaged  = clamp_d;
		s1_d.check_drive    = check_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_phase_q <= 1'b1;
			half_count_q  <= '0;
			checking_q    <= 1'b0;
			presence_q    <= TIP_ABSENT;
			sum_q         <= '0;
			min_q         <= '1;
			max_q         <= '0;
			idx_q         <= '0;
			heater_q      <= 1'b1;
			clamp_q       <= 1'b1;
			check_q       <= 1'b0;
		end else if (accept) begin
			first_phase_q <= first_phase_d;
			half_count_q  <= half_count_d;
			checking_q    <= checking_d;
			presence_q    <= presence_d;
			sum_q         <= sum_d;
			min_q         <= min_d;
			max_q         <= max_d;
			idx_q         <= idx_d;
			heater_q      <= heater_d;
			clamp_q       <= clamp_d;
			check_q       <= check_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_take) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_q <= s1_d;
		end
	end

	assign s1_valid = s1_valid_q;
	assign s1       = s1_q;

endmodule

// ===== design/tms_temp_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tms_temp_stage
// Converts the conversion average to Celsius and holds the result register.
// ----------------------------------------------------------------------------
module tms_temp_stage
	import tms_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s1_valid,
	input  tms_s1_t           s1,
	input  logic [TEMP_W-1:0] error_temperature,
	output logic              s1_take,
	tms_stream_if.source      results
);

	localparam logic [TEMP_RCP_W-1:0] RECIP_V = TEMP_RCP_W'(TEMP_RECIP);
	localparam int PROD_W = TEMP_X_W + TEMP_RCP_W;

	logic              s2_valid_q;
	tms_out_t          out_s2;
	tms_out_t          out_d;
	logic [TEMP_X_W-1:0] twice_avg;
	logic [PROD_W-1:0] prod;
	logic [TEMP_W-1:0] new_temp;

	assign s1_take = s1_valid && (!s2_valid_q || results.ready);

	// floor(2*avg/15) via reciprocal multiply
	assign twice_avg = {s1.avg, 1'b0};
	assign prod      = PROD_W'(twice_avg) * PROD_W'(RECIP_V);
	assign new_temp  = TEMP_W'(prod[TEMP_SHIFT +: TEMP_Q_W]) + TEMP_W'(TEMP_OFFSET);

	always_comb begin
		out_d.tip_status         = s1.tip_status;
		out_d.heater_allowed     = s1.heater_allowed;
		out_d.clamp_engaged      = s1.clamp_engaged;
		out_d.check_drive        = s1.check_drive;
		out_d.start_conversion   = s1.start_conversion;
		out_d.conversion_done    = s1.conversion_done;
		out_d.run_heater_control = s1.run_heater_control;
		// the result register always holds the latest temperature
		case (s1.temp_sel)
			TSEL_NEW:   out_d.tip_temperature = new_temp;
			TSEL_ERROR: out_d.tip_temperature = error_temperature;
			default:    out_d.tip_temperature = out_s2.tip_temperature;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
			out_s2     <= '0;
		end else begin
			if (s1_take) begin
				s2_valid_q <= 1'b1;
				out_s2     <= out_d;
			end else if (results.ready) begin
				s2_valid_q <= 1'b0;
			end
		end
	end

	assign results.valid = s2_valid_q;
	assign results.data  = out_s2;

endmodule

// ===== test/tms_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tms_result_checker
// Watches the event and result streams and the register port of the tip
// measure sequencer. Keeps its own copy of the sequencing state, predicts
// one result per accepted event and compares every accepted result with the
// oldest prediction, field by field.
// ----------------------------------------------------------------------------
module tms_result_checker
	import tms_pkg::*;
#(
	parameter int SAMPLES_PER_CONVERSION = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic                 ev_valid,
	input  logic                 ev_ready,
	input  tms_in_t              ev_data,
	input  logic                 res_valid,
	input  logic                 res_ready,
	input  tms_out_t             res_data,
	output int                   mismatches,
	output int                   pending
);

	tms_cfg_t            regs;
	logic                delay_phase_one;
	logic [COUNT_W-1:0]  half_cycles;
	logic                in_check;
	tip_status_t         presence;
	logic [TEMP_W-1:0]   temperature;
	int unsigned         acc_sum;
	logic [SAMPLE_W-1:0] acc_min;
	logic [SAMPLE_W-1:0] acc_max;
	int unsigned         acc_count;
	logic                heater_ok;
	logic                clamp_on;
	logic                check_on;

	tms_out_t expected_results[$];
	tms_out_t predicted;
	tms_out_t want;
	int       mismatch_total = 0;
	int       result_no = 0;

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned exp_val);
		$display("%0t ns result %0d: %s got 0x%0h expected 0x%0h",
			$realtime, result_no, what, got, exp_val);
		mismatch_total++;
	endtask

	task automatic clear_accumulators();
		acc_sum   = 0;
		acc_min   = '1;
		acc_max   = '0;
		acc_count = 0;
	endtask

	task automatic reset_state();
		regs.check_interval_cycles = CHECK_INTERVAL_RST;
		regs.max_deviation         = MAX_DEVIATION_RST;
		regs.tip_present_threshold = TIP_THRESHOLD_RST;
		regs.error_temperature     = ERROR_TEMP_RST;
		delay_phase_one = 1'b1;
		half_cycles     = '0;
		in_check        = 1'b0;
		presence        = TIP_ABSENT;
		temperature     = '0;
		heater_ok       = 1'b1;
		clamp_on        = 1'b1;
		check_on        = 1'b0;
		clear_accumulators();
	endtask

	// advance the sequencer state by one event and return what it reports
	task automatic predict_event(input tms_in_t ev, output tms_out_t r);
		int   avg;
		int   upper;
		int   lower;
		logic start;
		logic done;
		logic ask;
		start = 1'b0;
		done  = 1'b0;
		ask   = 1'b0;
		case (ev.command)
			CMD_HALF_CYCLE: begin
				if (half_cycles != '1)
					half_cycles++;
			end
			CMD_DELAY_TICK: begin
				if (delay_phase_one) begin
					delay_phase_one = 1'b0;
					heater_ok       = 1'b0;
					clamp_on        = 1'b0;
					if (half_cycles > regs.check_interval_cycles) begin
						in_check    = 1'b1;
						check_on    = 1'b1;
						half_cycles = '0;
					end
				end else begin
					delay_phase_one = 1'b1;
					start           = 1'b1;
					clear_accumulators();
				end
			end
			CMD_SAMPLE: begin
				acc_sum += ev.sample;
				if (ev.sample < acc_min)
					acc_min = ev.sample;
				if (ev.sample > acc_max)
					acc_max = ev.sample;
				acc_count++;
				if (acc_count >= SAMPLES_PER_CONVERSION) begin
					done      = 1'b1;
					avg       = int'(acc_sum / SAMPLES_PER_CONVERSION);
					clamp_on  = 1'b1;
					heater_ok = 1'b1;
					if (in_check) begin
						in_check = 1'b0;
						check_on = 1'b0;
						presence = (avg < int'(regs.tip_present_threshold)) ?
							TIP_PRESENT : TIP_ABSENT;
					end else if (presence == TIP_PRESENT) begin
						upper       = avg + int'(regs.max_deviation);
						lower       = avg - int'(regs.max_deviation);
						temperature = TEMP_W'(avg * 100 / 750 + 25);
						if (int'(acc_max) > upper || int'(acc_min) < lower) begin
							temperature = regs.error_temperature;
							presence    = TIP_DEV_FAULT;
						end else if (ev.system_active) begin
							ask = 1'b1;
						end
					end
					clear_accumulators();
				end
			end
			default: ;  // unused command: state untouched, no pulses
		endcase
		r.tip_temperature    = temperature;
		r.tip_status         = presence;
		r.heater_allowed     = heater_ok;
		r.clamp_engaged      = clamp_on;
		r.check_drive        = check_on;
		r.start_conversion   = start;
		r.conversion_done    = done;
		r.run_heater_control = ask;
	endtask

	task automatic compare_result(input tms_out_t got, input tms_out_t exp_r);
		if (got.tip_temperature !== exp_r.tip_temperature)
			report_mismatch("tip_temperature", got.tip_temperature, exp_r.tip_temperature);
		if (got.tip_status !== exp_r.tip_status)
			report_mismatch("tip_status", got.tip_status, exp_r.tip_status);
		if (got.heater_allowed !== exp_r.heater_allowed)
			report_mismatch("heater_allowed", got.heater_allowed, exp_r.heater_allowed);
		if (got.clamp_engaged !== exp_r.clamp_engaged)
			report_mismatch("clamp_engaged", got.clamp_engaged, exp_r.clamp_engaged);
		if (got.check_drive !== exp_r.check_drive)
			report_mismatch("check_drive", got.check_drive, exp_r.check_drive);
		if (got.start_conversion !== exp_r.start_conversion)
			report_mismatch("start_conversion", got.start_conversion,
				exp_r.start_conversion);
		if (got.conversion_done !== exp_r.conversion_done)
			report_mismatch("conversion_done", got.conversion_done, exp_r.conversion_done);
		if (got.run_heater_control !== exp_r.run_heater_control)
			report_mismatch("run_heater_control", got.run_heater_control,
				exp_r.run_heater_control);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_state();
			expected_results.delete();
			mismatches <= 0;
			pending    <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_CHECK_INTERVAL: regs.check_interval_cycles = cfg_wdata[COUNT_W-1:0];
					REG_MAX_DEVIATION:  regs.max_deviation         = cfg_wdata[DEV_W-1:0];
					REG_TIP_THRESHOLD:  regs.tip_present_threshold = cfg_wdata[SAMPLE_W-1:0];
					REG_ERROR_TEMP:     regs.error_temperature     = cfg_wdata[TEMP_W-1:0];
					default: ;
				endcase
			end
			if (res_valid && res_ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result with nothing expected", 32'(res_data), 0);
				end else begin
					want = expected_results.pop_front();
					compare_result(res_data, want);
				end
				result_no++;
			end
			if (ev_valid && ev_ready) begin
				predict_event(ev_data, predicted);
				expected_results.push_back(predicted);
			end
			mismatches <= mismatch_total;
			pending    <= expected_results.size();
		end
	end

endmodule

// ===== test/tb_thermocouple_tip_measure_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_thermocouple_tip_measure_sequencer
// Drives events into the tip measure sequencer: a directed opening, a long
// run of half cycles past a raised check interval, then random phases of
// measurement cycles and noise under several register settings, with
// random idling on both streams and one long result hold-off.
// ----------------------------------------------------------------------------
module tb_thermocouple_tip_measure_sequencer;
	import tms_pkg::*;

	localparam int          N_SAMPLES       = 16;
	localparam int          HALF_PERIOD     = 10;
	localparam int          WATCHDOG_LIMIT  = 1000;
	localparam int          HOLD_CYCLES     = 64;
	localparam int          DRAIN_CYCLES    = 8;
	localparam int          PHASE_ITEMS     = 68;
	localparam int          COUNT_RUN_ITEMS = 40;
	localparam logic [1:0]  CMD_UNUSED      = 2'd3;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_wdata = '0;

	tms_stream_if #(.T(tms_in_t))  events ();
	tms_stream_if #(.T(tms_out_t)) results ();

	int mismatches;
	int pending;
	int items_sent    = 0;
	int idle_cycles   = 0;
	int hold_requests = 0;
	int holds_served  = 0;
	bit gaps_on       = 1'b1;
	int cur_interval;
	int cur_dev;

	thermocouple_tip_measure_sequencer #(
		.SAMPLES_PER_CONVERSION(N_SAMPLES)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.events   (events),
		.results  (results)
	);

	tms_result_checker #(
		.SAMPLES_PER_CONVERSION(N_SAMPLES)
	) u_result_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.ev_valid  (events.valid),
		.ev_ready  (events.ready),
		.ev_data   (events.data),
		.res_valid (results.valid),
		.res_ready (results.ready),
		.res_data  (results.data),
		.mismatches(mismatches),
		.pending   (pending)
	);

	always begin
		#(HALF_PERIOD) clk = 1'b1;
		#(HALF_PERIOD) clk = 1'b0;
	end

	// no transaction on any port for too long means the block is hung
	always @(posedge clk) begin
		if (arst_n) begin
			if ((events.valid && events.ready) || (results.valid && results.ready) || cfg_we) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
				if (idle_cycles >= WATCHDOG_LIMIT) begin
					$display("end of test: mismatches");
					$finish;
				end
			end
		end
	end

	// result side: random stall bursts, plus the long hold-off on request
	initial begin
		results.ready = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_requests != holds_served) begin
				holds_served++;
				results.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (gaps_on && $urandom_range(0, 4) == 0) begin
				results.ready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end else begin
				results.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	task automatic send_event(input logic [1:0] cmd, input logic [SAMPLE_W-1:0] smp,
			input logic act);
		tms_in_t item;
		item.command       = cmd;
		item.sample        = smp;
		item.system_active = act;
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			events.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		events.valid <= 1'b1;
		events.data  <= item;
		@(posedge clk);
		while (!events.ready) @(posedge clk);
		items_sent++;
	endtask

	// drop valid and let every outstanding transaction come back
	task automatic wait_idle();
		events.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_config(input logic [CFG_W-1:0] interval, input logic [CFG_W-1:0] dev,
			input logic [CFG_W-1:0] thr, input logic [CFG_W-1:0] err);
		logic [CFG_W-1:0] vals[4];
		vals[0] = interval;
		vals[1] = dev;
		vals[2] = thr;
		vals[3] = err;
		wait_idle();
		for (int i = 0; i < 4; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= cfg_reg_t'(i);
			cfg_wdata <= vals[i];
			@(posedge clk);
		end
		cfg_we       <= 1'b0;
		cur_interval = int'(interval);
		cur_dev      = int'(dev[DEV_W-1:0]);
	endtask

	// half cycles, both delay phases, then up to one conversion's worth of samples
	task automatic run_measurement();
		int   hc;
		int   base;
		int   spread;
		int   n_samp;
		int   s;
		bit   probe;
		logic act;
		probe = ($urandom_range(0, 2) == 0);
		if (probe && cur_interval < 12)
			hc = cur_interval + 1 + $urandom_range(0, 2);
		else if (cur_interval == 0)
			hc = 0;
		else
			hc = $urandom_range(0, (cur_interval < 3) ? cur_interval : 3);
		act = ($urandom_range(0, 3) != 0);
		repeat (hc) send_event(CMD_HALF_CYCLE, SAMPLE_W'($urandom), act);
		send_event(CMD_DELAY_TICK, SAMPLE_W'($urandom), act);
		send_event(CMD_DELAY_TICK, SAMPLE_W'($urandom), act);
		base = $urandom_range(0, 4095);
		case ($urandom_range(0, 3))
			0:       spread = 0;
			1:       spread = cur_dev / 2;
			2:       spread = cur_dev + 1 + $urandom_range(0, 40);
			default: spread = $urandom_range(0, 4095);
		endcase
		// now and then a cut-short conversion
		n_samp = ($urandom_range(0, 7) == 0) ? $urandom_range(1, N_SAMPLES - 1) : N_SAMPLES;
		repeat (n_samp) begin
			s = base + int'($urandom_range(0, 2 * spread)) - spread;
			if (s < 0)
				s = 0;
			if (s > 4095)
				s = 4095;
			send_event(CMD_SAMPLE, SAMPLE_W'(s), ($urandom_range(0, 3) != 0) ? act : ~act);
		end
	endtask

	initial begin
		int  phase_start;
		bit  pressure_done;
		events.valid  = 1'b0;
		events.data   = '0;
		pressure_done = 1'b0;
		cur_interval  = int'(CHECK_INTERVAL_RST);
		cur_dev       = int'(MAX_DEVIATION_RST);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: unused command, one half cycle, both delay phases
		send_event(CMD_UNUSED, 12'hFFF, 1'b1);
		send_event(CMD_HALF_CYCLE, 12'h000, 1'b0);
		send_event(CMD_DELAY_TICK, 12'h000, 1'b1);
		send_event(CMD_DELAY_TICK, 12'hFFF, 1'b0);

		// interval 0 forces a presence check; extreme samples alternate
		write_config(16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000);
		send_event(CMD_HALF_CYCLE, 12'hFFF, 1'b1);
		send_event(CMD_DELAY_TICK, 12'h000, 1'b0);
		send_event(CMD_DELAY_TICK, 12'hFFF, 1'b1);
		for (int i = 0; i < N_SAMPLES; i++)
			send_event(CMD_SAMPLE, (i % 2) ? 12'hFFF : 12'h000, 1'(i % 2));

		// long half cycle run back to back, just past a raised interval
		write_config(16'h0020, 16'h0032, 16'h0FA0, 16'hFFFF);
		gaps_on = 1'b0;
		repeat (COUNT_RUN_ITEMS) send_event(CMD_HALF_CYCLE, SAMPLE_W'($urandom), 1'b1);
		gaps_on = 1'b1;
		repeat (3) send_event(CMD_DELAY_TICK, SAMPLE_W'($urandom), 1'b1);
		repeat (N_SAMPLES) send_event(CMD_SAMPLE, SAMPLE_W'($urandom_range(0, 1000)), 1'b1);

		for (int p = 0; p < 6; p++) begin
			case (p)
				0: write_config(16'h0000, 16'h0000, 16'h0FFF, 16'hFFFF);
				1: write_config(16'h0002, 16'hFFFF, 16'h0800, 16'h0000);
				2: write_config(CFG_W'($urandom_range(0, 6)), CFG_W'($urandom),
					CFG_W'($urandom), CFG_W'($urandom));
				3: write_config(16'hFFFF, 16'h0032, 16'h0000, 16'hA5A5);
				4: write_config(CFG_W'($urandom_range(0, 3)), CFG_W'($urandom),
					CFG_W'($urandom), CFG_W'($urandom));
				default: write_config(CFG_W'($urandom_range(0, 8)), CFG_W'($urandom),
					CFG_W'($urandom), CFG_W'($urandom));
			endcase
			if (p == 5)
				gaps_on = 1'b0;
			phase_start = items_sent;
			while (items_sent - phase_start < PHASE_ITEMS) begin
				if (p == 2 && !pressure_done && items_sent - phase_start > 20) begin
					hold_requests++;
					pressure_done = 1'b1;
				end
				if ($urandom_range(0, 3) == 0)
					repeat ($urandom_range(1, 3))
						send_event(2'($urandom_range(0, 3)), SAMPLE_W'($urandom), 1'($urandom));
				else
					run_measurement();
			end
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+design
design/tms_pkg.sv
design/tms_stream_if.sv
design/tms_cfg_regs.sv
design/tms_core.sv
design/tms_temp_stage.sv
design/thermocouple_tip_measure_sequencer.sv
test/tms_result_checker.sv
test/tb_thermocouple_tip_measure_sequencer.sv
